// ===== design/mig_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mig_pkg;

  localparam int MAX_DIM_DEF = 8;
  localparam int ELEM_W      = 32;
  localparam int ACC_W       = 48;
  localparam int HALF_W      = 24;
  localparam int DIM_W       = 4;
  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  typedef logic signed [ACC_W-1:0] acc_t;

  localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam acc_t ONE_Q24 = 48'sh000001000000;

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD_ID,
    S_PIV_RD, S_PIV_CMP, S_PIV_CHK,
    S_SWP_RD, S_SWP_WA, S_SWP_WB,
    S_RCP_GO, S_RCP_WT,
    S_SC_RD, S_SC_MUL, S_SC_WT,
    S_UP_FRD, S_UP_FCHK, S_UP_RD, S_UP_MUL, S_UP_WT, S_UP_NEXT,
    S_OUT_RD, S_OUT_LD, S_SING
  } state_t;

  typedef enum logic [2:0] {
    W_ELEM, W_ONE, W_ZERO, W_RDA, W_RDB, W_MUL, W_UPD
  } wsel_t;

  typedef struct packed {
    logic  re_a;
    logic  re_b;
    logic  we;
    wsel_t wsel;
    logic  piv_load;
    logic  f_load;
    logic  rcp_start;
    logic  mul_start;
    logic  mul_use_f;
    logic  out_load;
    logic  out_sing;
    logic  out_last;
  } cmd_t;

  typedef struct packed {
    logic rda_zero;
    logic rda_greater;
    logic piv_zero;
    logic rcp_done;
    logic mul_done;
    logic out_full;
  } sts_t;

  function automatic logic [ACC_W-1:0] mag48(input acc_t v);
    logic [ACC_W-1:0] neg_v;
    neg_v = ACC_W'(-v);
    return v[ACC_W-1] ? neg_v : ACC_W'(v);
  endfunction

endpackage
`default_nettype wire

// ===== design/mig_recip.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mig_recip import mig_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire acc_t p,
  output logic      done,
  output acc_t      res
);

  localparam int NUM_W = ACC_W + 1;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_r, q_r, q_nxt, rem_sh;
  logic [ACC_W-1:0] m_r, rem_r, rem_nxt;
  logic             neg_r, busy_r, done_r, ge;
  logic [CNT_W-1:0] cnt_r;
  acc_t             res_r, res_nxt;

  // restoring division, one quotient bit a cycle
  always_comb begin
    rem_sh  = {rem_r, num_r[NUM_W-1]};
    ge      = rem_sh >= {1'b0, m_r};
    rem_nxt = ge ? ACC_W'(rem_sh - {1'b0, m_r}) : ACC_W'(rem_sh);
    q_nxt   = {q_r[NUM_W-2:0], ge};
    if (q_nxt[NUM_W-1:ACC_W-1] != '0) begin
      res_nxt = neg_r ? ACC_MIN : ACC_MAX;
    end else begin
      res_nxt = neg_r ? -acc_t'(q_nxt[ACC_W-1:0]) : acc_t'(q_nxt[ACC_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      m_r   <= mag48(p);
      neg_r <= p[ACC_W-1];
      // numerator 2^48 plus half the divisor for rounding
      num_r <= (NUM_W'(1) << ACC_W) + NUM_W'(mag48(p) >> 1);
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      num_r <= num_r << 1;
      if (cnt_r == CNT_W'(1)) begin
        res_r <= res_nxt;
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule
`default_nettype wire

// ===== design/mig_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mig_mul import mig_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire acc_t a,
  input  wire acc_t b,
  output logic      done,
  output acc_t      res
);

  localparam int SUM_W  = ACC_W + 3;
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_LAST = 3'd5;

  logic [ACC_W-1:0]  ma_r, mb_r, pr_r;
  logic [HALF_W-1:0] x, y;
  logic [ACC_W:0]    rnd;
  logic [SUM_W-1:0]  acc_r;
  logic              neg_r, ovf_r, busy_r, done_r;
  logic [STEP_W-1:0] step_r;
  acc_t              res_r, res_nxt;

  // four 24x24 partial products through one multiplier
  always_comb begin
    case (step_r)
      3'd0: begin
        x = ma_r[ACC_W-1:HALF_W]; y = mb_r[ACC_W-1:HALF_W];
      end
      3'd1: begin
        x = ma_r[HALF_W-1:0];     y = mb_r[HALF_W-1:0];
      end
      3'd2: begin
        x = ma_r[ACC_W-1:HALF_W]; y = mb_r[HALF_W-1:0];
      end
      3'd3: begin
        x = ma_r[HALF_W-1:0];     y = mb_r[ACC_W-1:HALF_W];
      end
      default: begin
        x = '0; y = '0;
      end
    endcase
    rnd = {1'b0, pr_r} + (ACC_W+1)'(1 << (HALF_W - 1));
    if (ovf_r || acc_r[SUM_W-1:ACC_W-1] != '0) begin
      res_nxt = neg_r ? ACC_MIN : ACC_MAX;
    end else begin
      res_nxt = neg_r ? -acc_t'(acc_r[ACC_W-1:0]) : acc_t'(acc_r[ACC_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pr_r <= ACC_W'(x * y);
    if (start) begin
      ma_r  <= mag48(a);
      mb_r  <= mag48(b);
      neg_r <= a[ACC_W-1] ^ b[ACC_W-1];
    end else if (busy_r) begin
      case (step_r)
        3'd1: begin
          ovf_r <= |pr_r[ACC_W-1:HALF_W];
          acc_r <= {3'b000, pr_r[HALF_W-1:0], {HALF_W{1'b0}}};
        end
        3'd2:    acc_r <= acc_r + SUM_W'(rnd[ACC_W:HALF_W]);
        3'd3:    acc_r <= acc_r + SUM_W'(pr_r);
        3'd4:    acc_r <= acc_r + SUM_W'(pr_r);
        3'd5:    res_r <= res_nxt;
        default: ;
      endcase
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule
`default_nettype wire

// ===== design/mig_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mig_dpath import mig_pkg::*; #(
  parameter int AW = 7
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire cmd_t                     cmd,
  input  wire logic [AW-1:0]            addr_a,
  input  wire logic [AW-1:0]            addr_b,
  input  wire logic [AW-1:0]            waddr,
  output sts_t                          sts,
  input  wire logic signed [ELEM_W-1:0] in_element,
  output logic signed [ELEM_W-1:0]      out_value,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          out_last,
  output logic                          out_singular,
  output logic                          out_saturated
);

  localparam int DEPTH = 1 << AW;
  localparam int RND_W = ACC_W - 8 + 1;

  acc_t             mem_r [DEPTH];
  acc_t             rda_r, rdb_r, wdata;
  logic [ACC_W-1:0] best_mag_r;
  acc_t             piv_r, f_r, scale, prod, mul_b, upd;
  logic             rcp_done, mul_done;
  logic signed [ACC_W:0] sum;

  logic [ACC_W-1:0]        omag;
  logic [ACC_W:0]          oround;
  logic [RND_W-1:0]        om;
  logic                    oneg, osat;
  logic signed [ELEM_W-1:0] oval;

  logic                     out_valid_r, out_last_r, out_sing_r, out_sat_r;
  logic signed [ELEM_W-1:0] out_value_r;

  always_ff @(posedge clk) begin
    if (cmd.we) mem_r[waddr] <= wdata;
    if (cmd.re_a) rda_r <= mem_r[addr_a];
    if (cmd.re_b) rdb_r <= mem_r[addr_b];
  end

  always_ff @(posedge clk) begin
    if (cmd.piv_load) begin
      best_mag_r <= mag48(rda_r);
      piv_r      <= rda_r;
    end
    if (cmd.f_load) begin
      f_r <= (rda_r == ACC_MIN) ? ACC_MAX : -rda_r;
    end
  end

  mig_recip u_rcp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.rcp_start),
    .p     (piv_r),
    .done  (rcp_done),
    .res   (scale)
  );

  assign mul_b = cmd.mul_use_f ? f_r : scale;

  mig_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (rda_r),
    .b     (mul_b),
    .done  (mul_done),
    .res   (prod)
  );

  always_comb begin
    sum = {rdb_r[ACC_W-1], rdb_r} + {prod[ACC_W-1], prod};
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      upd = sum[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      upd = acc_t'(sum[ACC_W-1:0]);
    end
    case (cmd.wsel)
      W_ELEM:  wdata = {{8{in_element[ELEM_W-1]}}, in_element, 8'h00};
      W_ONE:   wdata = ONE_Q24;
      W_ZERO:  wdata = '0;
      W_RDA:   wdata = rda_r;
      W_RDB:   wdata = rdb_r;
      W_MUL:   wdata = prod;
      W_UPD:   wdata = upd;
      default: wdata = '0;
    endcase
  end

  // q24.24 to q16.16, round half away from zero, clip
  always_comb begin
    oneg   = rda_r[ACC_W-1];
    omag   = mag48(rda_r);
    oround = {1'b0, omag} + (ACC_W+1)'(128);
    om     = oround[ACC_W:8];
    if (!oneg && om > RND_W'(32'h7fff_ffff)) begin
      osat = 1'b1;
      oval = 32'sh7fff_ffff;
    end else if (oneg && om > RND_W'(32'h8000_0000)) begin
      osat = 1'b1;
      oval = 32'sh8000_0000;
    end else begin
      osat = 1'b0;
      oval = oneg ? -$signed(om[ELEM_W-1:0]) : $signed(om[ELEM_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value_r <= cmd.out_sing ? '0 : oval;
      out_sat_r   <= cmd.out_sing ? 1'b0 : osat;
      out_sing_r  <= cmd.out_sing;
      out_last_r  <= cmd.out_last;
    end
  end

  assign sts.rda_zero    = (rda_r == '0);
  assign sts.rda_greater = (mag48(rda_r) > best_mag_r);
  assign sts.piv_zero    = (piv_r == '0);
  assign sts.rcp_done    = rcp_done;
  assign sts.mul_done    = mul_done;
  assign sts.out_full    = out_valid_r & ~out_ready;

  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_last      = out_last_r;
  assign out_singular  = out_sing_r;
  assign out_saturated = out_sat_r;

endmodule
`default_nettype wire

// ===== design/mig_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mig_ctrl import mig_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic [$clog2(MAX_DIM+1)-1:0]     n,
  input  wire logic                             cfg_wr,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire sts_t                             sts,
  output cmd_t                                  cmd,
  output logic [2*$clog2(MAX_DIM):0]            addr_a,
  output logic [2*$clog2(MAX_DIM):0]            addr_b,
  output logic [2*$clog2(MAX_DIM):0]            waddr
);

  localparam int RW = $clog2(MAX_DIM);
  localparam int CW = RW + 1;
  localparam int NW = $clog2(MAX_DIM + 1);

  state_t        state_r, state_nxt;
  logic [RW-1:0] lrow_r, lrow_nxt, lcol_r, lcol_nxt;
  logic [RW-1:0] pc_r, pc_nxt, r_r, r_nxt, best_r, best_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [RW-1:0] nm1;
  logic [CW-1:0] jlast, ncol;
  logic          take_best;

  assign nm1       = RW'(n - NW'(1));
  assign jlast     = {nm1, 1'b1};
  assign ncol      = CW'(n);
  assign take_best = (r_r == pc_r) || sts.rda_greater;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      lrow_r  <= '0;
      lcol_r  <= '0;
      pc_r    <= '0;
      r_r     <= '0;
      best_r  <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      lrow_r  <= lrow_nxt;
      lcol_r  <= lcol_nxt;
      pc_r    <= pc_nxt;
      r_r     <= r_nxt;
      best_r  <= best_nxt;
      j_r     <= j_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    lrow_nxt  = lrow_r;
    lcol_nxt  = lcol_r;
    pc_nxt    = pc_r;
    r_nxt     = r_r;
    best_nxt  = best_r;
    j_nxt     = j_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_LOAD_ID;
      end
      S_LOAD_ID: begin
        state_nxt = S_IDLE;
        if (lcol_r == nm1) begin
          lcol_nxt = '0;
          if (lrow_r == nm1) begin
            lrow_nxt  = '0;
            pc_nxt    = '0;
            r_nxt     = '0;
            state_nxt = S_PIV_RD;
          end else begin
            lrow_nxt = lrow_r + RW'(1);
          end
        end else begin
          lcol_nxt = lcol_r + RW'(1);
        end
      end
      S_PIV_RD: state_nxt = S_PIV_CMP;
      S_PIV_CMP: begin
        if (take_best) best_nxt = r_r;
        if (r_r == nm1) begin
          state_nxt = S_PIV_CHK;
        end else begin
          r_nxt     = r_r + RW'(1);
          state_nxt = S_PIV_RD;
        end
      end
      S_PIV_CHK: begin
        j_nxt = '0;
        if (sts.piv_zero) state_nxt = S_SING;
        else if (best_r != pc_r) state_nxt = S_SWP_RD;
        else state_nxt = S_RCP_GO;
      end
      S_SWP_RD: state_nxt = S_SWP_WA;
      S_SWP_WA: state_nxt = S_SWP_WB;
      S_SWP_WB: begin
        if (j_r == jlast) begin
          state_nxt = S_RCP_GO;
        end else begin
          j_nxt     = j_r + CW'(1);
          state_nxt = S_SWP_RD;
        end
      end
      S_RCP_GO: state_nxt = S_RCP_WT;
      S_RCP_WT: begin
        j_nxt = '0;
        if (sts.rcp_done) state_nxt = S_SC_RD;
      end
      S_SC_RD:  state_nxt = S_SC_MUL;
      S_SC_MUL: state_nxt = S_SC_WT;
      S_SC_WT: begin
        if (sts.mul_done) begin
          if (j_r == jlast) begin
            r_nxt     = '0;
            state_nxt = S_UP_FRD;
          end else begin
            j_nxt     = j_r + CW'(1);
            state_nxt = S_SC_RD;
          end
        end
      end
      S_UP_FRD: begin
        if (r_r == pc_r) state_nxt = S_UP_NEXT;
        else state_nxt = S_UP_FCHK;
      end
      S_UP_FCHK: begin
        j_nxt = '0;
        if (sts.rda_zero) state_nxt = S_UP_NEXT;
        else state_nxt = S_UP_RD;
      end
      S_UP_RD:  state_nxt = S_UP_MUL;
      S_UP_MUL: state_nxt = S_UP_WT;
      S_UP_WT: begin
        if (sts.mul_done) begin
          if (j_r == jlast) begin
            state_nxt = S_UP_NEXT;
          end else begin
            j_nxt     = j_r + CW'(1);
            state_nxt = S_UP_RD;
          end
        end
      end
      S_UP_NEXT: begin
        if (r_r == nm1) begin
          if (pc_r == nm1) begin
            r_nxt     = '0;
            j_nxt     = '0;
            state_nxt = S_OUT_RD;
          end else begin
            pc_nxt    = pc_r + RW'(1);
            r_nxt     = pc_r + RW'(1);
            state_nxt = S_PIV_RD;
          end
        end else begin
          r_nxt     = r_r + RW'(1);
          state_nxt = S_UP_FRD;
        end
      end
      S_OUT_RD: state_nxt = S_OUT_LD;
      S_OUT_LD: begin
        if (!sts.out_full) begin
          if (j_r == CW'(nm1)) begin
            j_nxt = '0;
            if (r_r == nm1) begin
              state_nxt = S_IDLE;
            end else begin
              r_nxt     = r_r + RW'(1);
              state_nxt = S_OUT_RD;
            end
          end else begin
            j_nxt     = j_r + CW'(1);
            state_nxt = S_OUT_RD;
          end
        end
      end
      S_SING: begin
        if (!sts.out_full) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    // new dimension abandons a partial load
    if (cfg_wr) begin
      lrow_nxt = '0;
      lcol_nxt = '0;
    end
  end

  always_comb begin
    cmd      = '0;
    addr_a   = '0;
    addr_b   = '0;
    waddr    = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.we   = in_valid;
        cmd.wsel = W_ELEM;
        waddr    = {lrow_r, CW'(lcol_r)};
      end
      S_LOAD_ID: begin
        cmd.we   = 1'b1;
        cmd.wsel = (lrow_r == lcol_r) ? W_ONE : W_ZERO;
        waddr    = {lrow_r, CW'(CW'(lcol_r) + ncol)};
      end
      S_PIV_RD: begin
        cmd.re_a = 1'b1;
        addr_a   = {r_r, CW'(pc_r)};
      end
      S_PIV_CMP: cmd.piv_load = take_best;
      S_SWP_RD: begin
        cmd.re_a = 1'b1;
        cmd.re_b = 1'b1;
        addr_a   = {pc_r, j_r};
        addr_b   = {best_r, j_r};
      end
      S_SWP_WA: begin
        cmd.we   = 1'b1;
        cmd.wsel = W_RDB;
        waddr    = {pc_r, j_r};
      end
      S_SWP_WB: begin
        cmd.we   = 1'b1;
        cmd.wsel = W_RDA;
        waddr    = {best_r, j_r};
      end
      S_RCP_GO: cmd.rcp_start = 1'b1;
      S_SC_RD: begin
        cmd.re_a = 1'b1;
        addr_a   = {pc_r, j_r};
      end
      S_SC_MUL: cmd.mul_start = 1'b1;
      S_SC_WT: begin
        cmd.we   = sts.mul_done;
        cmd.wsel = W_MUL;
        waddr    = {pc_r, j_r};
      end
      S_UP_FRD: begin
        cmd.re_a = (r_r != pc_r);
        addr_a   = {r_r, CW'(pc_r)};
      end
      S_UP_FCHK: cmd.f_load = ~sts.rda_zero;
      S_UP_RD: begin
        cmd.re_a = 1'b1;
        cmd.re_b = 1'b1;
        addr_a   = {pc_r, j_r};
        addr_b   = {r_r, j_r};
      end
      S_UP_MUL: begin
        cmd.mul_start = 1'b1;
        cmd.mul_use_f = 1'b1;
      end
      S_UP_WT: begin
        cmd.we   = sts.mul_done;
        cmd.wsel = W_UPD;
        waddr    = {r_r, j_r};
      end
      S_OUT_RD: begin
        cmd.re_a = 1'b1;
        addr_a   = {r_r, CW'(j_r + ncol)};
      end
      S_OUT_LD: begin
        cmd.out_load = ~sts.out_full;
        cmd.out_last = (r_r == nm1) && (j_r == CW'(nm1));
      end
      S_SING: begin
        cmd.out_load = ~sts.out_full;
        cmd.out_sing = 1'b1;
        cmd.out_last = 1'b1;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/matrix_inverse_gauss_jordan_top.sv =====
// channel   signals                                   direction
// in        in_valid, in_ready, in_element            matrix elements, row-major
// out       out_valid, out_ready, out_value,          inverse elements, row-major
//           out_last, out_singular, out_saturated
// cfg       psel, penable, pwrite, paddr, pwdata,     dimension register at 0x0
//           prdata, pready
//
// loading writes each item, then its identity entry (element write, then identity write, one memory port)
// each column: a pivot search over rows c..n-1, a row swap over all 2n columns, the
// reciprocal, then up to 2n(n) scale and update products;
// the single 24x24 multiplier sets the run time
// results then leave through one output register; a stalled out_ready holds the run in place
// synchronous active-low reset; the store is not cleared, every entry is written first
`timescale 1ns / 1ps
`default_nettype none
module matrix_inverse_gauss_jordan_top import mig_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic signed [ELEM_W-1:0] in_element,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [ELEM_W-1:0]      out_value,
  output logic                          out_last,
  output logic                          out_singular,
  output logic                          out_saturated,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [2:0]               paddr,
  input  wire logic [31:0]              pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int RW = $clog2(MAX_DIM);
  localparam int AW = 2 * RW + 1;
  localparam int NW = $clog2(MAX_DIM + 1);

  logic [DIM_W-1:0] dim_r;
  logic [NW-1:0]    n_eff;
  logic             cfg_wr, reg_hit;
  cmd_t             cmd;
  sts_t             sts;
  logic [AW-1:0]    addr_a, addr_b, waddr;

  assign reg_hit = (paddr[2] == 1'b0);
  assign cfg_wr  = psel & penable & pwrite & reg_hit;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? 32'(dim_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= DIM_RESET;
    end else if (cfg_wr) begin
      dim_r <= pwdata[DIM_W-1:0];
    end
  end

  // zero acts as one, oversize clamps
  always_comb begin
    if (dim_r == '0) n_eff = NW'(1);
    else if (int'(dim_r) > MAX_DIM) n_eff = NW'(MAX_DIM);
    else n_eff = NW'(dim_r);
  end

  mig_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .n        (n_eff),
    .cfg_wr   (cfg_wr),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd),
    .addr_a   (addr_a),
    .addr_b   (addr_b),
    .waddr    (waddr)
  );

  mig_dpath #(.AW(AW)) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .addr_a        (addr_a),
    .addr_b        (addr_b),
    .waddr         (waddr),
    .sts           (sts),
    .in_element    (in_element),
    .out_value     (out_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_last      (out_last),
    .out_singular  (out_singular),
    .out_saturated (out_saturated)
  );

endmodule
`default_nettype wire

// ===== design/mig_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mig_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_value,
  input wire logic        out_last,
  input wire logic        out_singular,
  input wire logic        out_saturated
);

  // a stalled item holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_last))
    else $error("result changed while stalled");

  a_sing_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |-> out_last && out_value == 32'h0 && !out_saturated)
    else $error("singular item malformed");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> out_value == 32'h7fff_ffff || out_value == 32'h8000_0000)
    else $error("saturated item not at a range limit");

  // each element is followed by its identity entry write, during which in_ready is low
  a_load_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted on consecutive cycles");

endmodule

bind matrix_inverse_gauss_jordan_top mig_checker u_chk (.*);
`default_nettype wire
